>>> sv/afd_pkg.sv
// Package with shared types, codes and constants of the API frame deframer.
package afd_pkg;

  localparam int MAX_DATA_DEF = 128;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] START_CODE = 8'h7E;
  localparam logic [7:0] ESCAPE_CODE = 8'h7D;
  localparam logic [7:0] ESCAPE_XOR = 8'h20;
  localparam logic [7:0] SUM_GOOD = 8'hFF;

  // Frame positions held by the front part.
  localparam int POS_HUNT = 0;
  localparam int POS_LEN_HI = 1;
  localparam int POS_LEN_LO = 2;
  localparam int POS_API = 3;
  localparam int POS_DATA0 = 4;

  typedef enum logic [2:0] {
    EV_DATA = 3'd0,
    EV_GOOD = 3'd1,
    EV_CHECKSUM = 3'd2,
    EV_START = 3'd3,
    EV_TOO_LONG = 3'd4
  } ev_t;

  // Work orders passed from the front part to the back part.
  typedef enum logic [2:0] {
    OP_API = 3'd0,
    OP_DATA = 3'd1,
    OP_END = 3'd2,
    OP_START = 3'd3,
    OP_LONG = 3'd4
  } op_t;

  typedef struct packed {
    op_t op;
    logic [7:0] dbyte;
    logic [7:0] aux;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

>>> sv/afd_front.sv
// Front part: accepts raw bytes, tracks the frame position and classifies each byte.
module afd_front #(
  parameter int MAX_DATA = afd_pkg::MAX_DATA_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  input  logic               cfg_valid,
  input  logic               cfg_escape_enable,
  input  afd_pkg::q_status_t q_status,
  output logic               q_push,
  output afd_pkg::entry_t    q_entry
);

  localparam int POS_W = $clog2(MAX_DATA + 5);
  localparam int CMP_W = ((POS_W > 16) ? POS_W : 16) + 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_DATA + 3);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             esc_r, esc_nxt;
  logic [15:0]      len_r, len_nxt;
  logic             esc_en_r;

  logic             take;
  logic             skip;
  logic [7:0]       eb;
  logic [POS_W-1:0] data_off;
  logic [CMP_W-1:0] end_pos;

  assign take = in_valid && !q_status.full;
  assign data_off = pos_r - POS_W'(afd_pkg::POS_DATA0);
  assign end_pos = CMP_W'(len_r) + CMP_W'(afd_pkg::POS_API);

  always_comb begin
    pos_nxt = pos_r;
    esc_nxt = esc_r;
    len_nxt = len_r;
    skip = 1'b0;
    eb = in_rx_byte;
    q_push = 1'b0;
    q_entry.op = afd_pkg::OP_DATA;
    q_entry.dbyte = eb;
    q_entry.aux = 8'(data_off);
    if (take) begin
      if (esc_en_r && (pos_r != POS_W'(afd_pkg::POS_HUNT))) begin
        if (in_rx_byte == afd_pkg::START_CODE) begin
          q_push = 1'b1;
          q_entry.op = afd_pkg::OP_START;
          pos_nxt = '0;
          esc_nxt = 1'b0;
          len_nxt = '0;
          skip = 1'b1;
        end else if (esc_r) begin
          eb = in_rx_byte ^ afd_pkg::ESCAPE_XOR;
          esc_nxt = 1'b0;
        end else if (in_rx_byte == afd_pkg::ESCAPE_CODE) begin
          esc_nxt = 1'b1;
          skip = 1'b1;
        end
      end
      q_entry.dbyte = eb;
      if (!skip) begin
        if (pos_r == POS_W'(afd_pkg::POS_HUNT)) begin
          if (eb == afd_pkg::START_CODE) begin
            pos_nxt = POS_W'(afd_pkg::POS_LEN_HI);
          end
        end else if (pos_r == POS_W'(afd_pkg::POS_LEN_HI)) begin
          len_nxt = {eb, 8'h00};
          pos_nxt = POS_W'(afd_pkg::POS_LEN_LO);
        end else if (pos_r == POS_W'(afd_pkg::POS_LEN_LO)) begin
          len_nxt = {len_r[15:8], eb};
          pos_nxt = POS_W'(afd_pkg::POS_API);
        end else if (pos_r == POS_W'(afd_pkg::POS_API)) begin
          q_push = 1'b1;
          q_entry.op = afd_pkg::OP_API;
          pos_nxt = POS_W'(afd_pkg::POS_DATA0);
        end else if (CMP_W'(pos_r) == end_pos) begin
          // Checksum byte is recognized before the length limit.
          q_push = 1'b1;
          q_entry.op = afd_pkg::OP_END;
          pos_nxt = '0;
          esc_nxt = 1'b0;
          len_nxt = '0;
        end else if (pos_r > POS_LIMIT) begin
          q_push = 1'b1;
          q_entry.op = afd_pkg::OP_LONG;
          pos_nxt = '0;
          esc_nxt = 1'b0;
          len_nxt = '0;
        end else begin
          q_push = 1'b1;
          q_entry.op = afd_pkg::OP_DATA;
          pos_nxt = pos_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      esc_r <= 1'b0;
      len_r <= '0;
      esc_en_r <= 1'b1;
    end else begin
      pos_r <= pos_nxt;
      esc_r <= esc_nxt;
      len_r <= len_nxt;
      if (cfg_valid) begin
        esc_en_r <= cfg_escape_enable;
      end
    end
  end

endmodule

>>> sv/afd_queue.sv
// Short register queue between the front and back parts.
module afd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  afd_pkg::entry_t    push_entry,
  input  logic               pop,
  output afd_pkg::entry_t    head,
  output afd_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(afd_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(afd_pkg::QUEUE_DEPTH + 1);

  afd_pkg::entry_t  mem_r [afd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head = mem_r[rd_ptr_r];
  assign status.full = (cnt_r == CNT_W'(afd_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(afd_pkg::QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> sv/afd_back.sv
// Back part: keeps the checksum sum and API id and builds the result requests.
module afd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  afd_pkg::q_status_t q_status,
  input  afd_pkg::entry_t    head,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [2:0]         out_event_res,
  output logic [7:0]         out_data_byte,
  output logic [6:0]         out_data_index,
  output logic [7:0]         out_api_id,
  output logic [7:0]         out_data_length,
  output logic [7:0]         out_checksum_byte
);

  logic             sum_ok;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       api_r, api_nxt;
  logic             vld_r, vld_nxt;
  afd_pkg::ev_t     ev_r, ev_nxt;
  logic [7:0]       db_r, db_nxt;
  logic [6:0]       idx_r, idx_nxt;
  logic [7:0]       oapi_r, oapi_nxt;
  logic [7:0]       dlen_r, dlen_nxt;
  logic [7:0]       cks_r, cks_nxt;

  assign pop = !q_status.empty && (!vld_r || !out_stall);
  assign sum_ok = ((sum_r + head.dbyte) == afd_pkg::SUM_GOOD);

  always_comb begin
    sum_nxt = sum_r;
    api_nxt = api_r;
    vld_nxt = vld_r && out_stall;
    ev_nxt = ev_r;
    db_nxt = db_r;
    idx_nxt = idx_r;
    oapi_nxt = oapi_r;
    dlen_nxt = dlen_r;
    cks_nxt = cks_r;
    if (pop) begin
      db_nxt = '0;
      idx_nxt = '0;
      oapi_nxt = api_r;
      dlen_nxt = '0;
      cks_nxt = '0;
      vld_nxt = 1'b1;
      unique case (head.op)
        afd_pkg::OP_API: begin
          sum_nxt = head.dbyte;
          api_nxt = head.dbyte;
          vld_nxt = 1'b0;
        end
        afd_pkg::OP_DATA: begin
          sum_nxt = sum_r + head.dbyte;
          ev_nxt = afd_pkg::EV_DATA;
          db_nxt = head.dbyte;
          idx_nxt = head.aux[6:0];
        end
        afd_pkg::OP_END: begin
          if (sum_ok) begin
            ev_nxt = afd_pkg::EV_GOOD;
            dlen_nxt = head.aux;
            cks_nxt = head.dbyte;
          end else begin
            ev_nxt = afd_pkg::EV_CHECKSUM;
          end
          sum_nxt = '0;
          api_nxt = '0;
        end
        afd_pkg::OP_START: begin
          ev_nxt = afd_pkg::EV_START;
          sum_nxt = '0;
          api_nxt = '0;
        end
        afd_pkg::OP_LONG: begin
          ev_nxt = afd_pkg::EV_TOO_LONG;
          sum_nxt = '0;
          api_nxt = '0;
        end
        default: begin
          vld_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      api_r <= '0;
      vld_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      api_r <= api_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
    db_r <= db_nxt;
    idx_r <= idx_nxt;
    oapi_r <= oapi_nxt;
    dlen_r <= dlen_nxt;
    cks_r <= cks_nxt;
  end

  assign out_valid = vld_r;
  assign out_event_res = ev_r;
  assign out_data_byte = db_r;
  assign out_data_index = idx_r;
  assign out_api_id = oapi_r;
  assign out_data_length = dlen_r;
  assign out_checksum_byte = cks_r;

endmodule

>>> sv/api_frame_deframer_unit.sv
// Top level of the API frame deframer: front classifier, request queue and back part.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_stall    in_rx_byte
//   out_      output     out_valid / out_stall  out_event_res, out_data_byte, out_data_index,
//                                               out_api_id, out_data_length, out_checksum_byte
//   cfg_      input      cfg_valid / cfg_ready  cfg_escape_enable
//
// One request is accepted every cycle while the queue is not full; a result passes through the
// queue and then the output register after its byte is taken. The front part's frame position update sets that rate.
// Reset is synchronous and active low; escaped mode is selected after reset.
// in_stall rises only when the two-entry queue between front and back is full; with bytes
// arriving back to back, a single cycle of out_stall on a waiting result is enough to fill it.
// cfg_ready is always high; writes take effect on the next accepted byte.
module api_frame_deframer_unit #(
  parameter int MAX_DATA = afd_pkg::MAX_DATA_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_res,
  output logic [7:0] out_data_byte,
  output logic [6:0] out_data_index,
  output logic [7:0] out_api_id,
  output logic [7:0] out_data_length,
  output logic [7:0] out_checksum_byte,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_escape_enable
);

  logic               q_push;
  logic               q_pop;
  afd_pkg::entry_t    q_entry;
  afd_pkg::entry_t    q_head;
  afd_pkg::q_status_t q_status;

  // The register write needs no wait state.
  assign cfg_ready = 1'b1;

  // Bytes are held off only while the queue has no free slot.
  assign in_stall = q_status.full;

  // The front part follows start, length, API id, data and checksum positions
  // and turns every byte that matters into one request for the back part.
  afd_front #(
    .MAX_DATA (MAX_DATA)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_rx_byte        (in_rx_byte),
    .cfg_valid         (cfg_valid),
    .cfg_escape_enable (cfg_escape_enable),
    .q_status          (q_status),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  afd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_status)
  );

  // The back part owns the running checksum and the API id, and drives the
  // output register that the downstream side may stall.
  afd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_status          (q_status),
    .head              (q_head),
    .pop               (q_pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_data_index    (out_data_index),
    .out_api_id        (out_api_id),
    .out_data_length   (out_data_length),
    .out_checksum_byte (out_checksum_byte)
  );

`ifndef SYNTH
  // The front part never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("request pushed into a full queue");

  // The back part never pops from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("request popped from an empty queue");

  // Only a data result carries a data byte or an index.
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res != afd_pkg::EV_DATA))
      |-> ((out_data_byte == 8'h00) && (out_data_index == 7'h00)))
    else $error("data fields set on a non-data result");

  // Length and checksum fields are only set on a good frame.
  a_good_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_res != afd_pkg::EV_GOOD))
      |-> ((out_data_length == 8'h00) && (out_checksum_byte == 8'h00)))
    else $error("frame fields set on a result other than frame good");
`endif

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the API frame deframer with its own frame predictor.
`timescale 1ns / 1ps

module tb_top;

  // The buffer size that the block is built with; the predictor uses the same value.
  localparam int FRAME_MAX_DATA = afd_pkg::MAX_DATA_DEF;
  // This is a safety net for a hung run. It sits far above the slowest legal run of
  // about 1100 requests.
  localparam int CYCLE_LIMIT = 400000;
  // This is the number of extra cycles allowed for a byte still in flight that gives no result.
  localparam int SETTLE_CYCLES = 8;

  // This is one expected or observed result, with the fields at the port widths.
  typedef struct packed {
    afd_pkg::ev_t event_res;
    logic [7:0]   data_byte;
    logic [6:0]   data_index;
    logic [7:0]   api_id;
    logic [7:0]   data_length;
    logic [7:0]   checksum_byte;
  } deframed_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] out_event_res;
  logic [7:0] out_data_byte;
  logic [6:0] out_data_index;
  logic [7:0] out_api_id;
  logic [7:0] out_data_length;
  logic [7:0] out_checksum_byte;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_escape_enable = 1'b1;

  // The serial bytes wait here until the driver presents them, and the predicted results
  // wait here until the block delivers them.
  logic [7:0] rx_bytes_q[$];
  deframed_t  events_due[$];
  // This holds the data bytes of the frame that is being built for the next put_frame call.
  logic [7:0] body_q[$];

  int mismatches = 0;
  int cycle_count = 0;
  int bytes_built = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // This is the predictor's copy of the block state. It starts at the reset values because
  // reset is asserted only once, at time zero.
  logic        esc_mode = 1'b1;
  int          fr_pos = afd_pkg::POS_HUNT;
  logic        fr_esc = 1'b0;
  logic [7:0]  fr_sum = 8'h00;
  logic [15:0] fr_len = 16'h0000;
  logic [7:0]  fr_api = 8'h00;

  api_frame_deframer_unit #(
    .MAX_DATA(FRAME_MAX_DATA)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_event_res(out_event_res),
    .out_data_byte(out_data_byte),
    .out_data_index(out_data_index),
    .out_api_id(out_api_id),
    .out_data_length(out_data_length),
    .out_checksum_byte(out_checksum_byte),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_escape_enable(cfg_escape_enable)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic void clear_frame();
    fr_pos = afd_pkg::POS_HUNT;
    fr_esc = 1'b0;
    fr_sum = 8'h00;
    fr_len = 16'h0000;
    fr_api = 8'h00;
  endfunction

  // This advances the frame state by one received byte. It returns 1 when the byte
  // produces a result, and that result is passed back in res.
  function automatic bit deframe_byte(input logic [7:0] raw, output deframed_t res);
    logic [7:0] b;
    b = raw;
    res = '0;
    // The API id is updated only by a byte that gives no result, so it can be taken here.
    res.api_id = fr_api;
    // Unescaping and the start check apply only in escaped mode and only after the start.
    if (esc_mode && fr_pos != afd_pkg::POS_HUNT) begin
      if (b == afd_pkg::START_CODE) begin
        // An unexpected start ends the frame. That byte does not open a new frame.
        res.event_res = afd_pkg::EV_START;
        clear_frame();
        return 1'b1;
      end
      if (fr_esc) begin
        b = b ^ afd_pkg::ESCAPE_XOR;
        fr_esc = 1'b0;
      end else if (b == afd_pkg::ESCAPE_CODE) begin
        fr_esc = 1'b1;
        return 1'b0;
      end
    end
    if (fr_pos >= afd_pkg::POS_API) begin
      fr_sum = fr_sum + b;
    end
    case (fr_pos)
      afd_pkg::POS_HUNT: begin
        if (b == afd_pkg::START_CODE) begin
          fr_pos = afd_pkg::POS_LEN_HI;
        end
        return 1'b0;
      end
      afd_pkg::POS_LEN_HI: begin
        fr_len = {b, 8'h00};
        fr_pos = afd_pkg::POS_LEN_LO;
        return 1'b0;
      end
      afd_pkg::POS_LEN_LO: begin
        fr_len[7:0] = b;
        fr_pos = afd_pkg::POS_API;
        return 1'b0;
      end
      afd_pkg::POS_API: begin
        fr_api = b;
        fr_pos = afd_pkg::POS_DATA0;
        return 1'b0;
      end
      default: ;
    endcase
    // The checksum position is tested before the size limit, so a full buffer still passes.
    if (fr_pos == int'(fr_len) + 3) begin
      if (fr_sum == afd_pkg::SUM_GOOD) begin
        res.event_res = afd_pkg::EV_GOOD;
        res.data_length = 8'(fr_pos - afd_pkg::POS_DATA0);
        res.checksum_byte = b;
      end else begin
        res.event_res = afd_pkg::EV_CHECKSUM;
      end
      clear_frame();
      return 1'b1;
    end
    if (fr_pos > FRAME_MAX_DATA + 3) begin
      res.event_res = afd_pkg::EV_TOO_LONG;
      clear_frame();
      return 1'b1;
    end
    res.data_byte = b;
    res.data_index = 7'(fr_pos - afd_pkg::POS_DATA0);
    fr_pos++;
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // This draws a byte value. A quarter of the draws fall on the codes and on the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(15))
      0: return afd_pkg::START_CODE;
      1: return afd_pkg::ESCAPE_CODE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic put_raw(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_built++;
  endtask

  // This sends a byte as a well-behaved transmitter would in the current mode. In escaped mode
  // the start and escape codes are always escaped, and a few other bytes are escaped too,
  // because the receiver must accept an escape in front of any byte.
  task automatic put_coded(input logic [7:0] b);
    if (esc_mode && (b == afd_pkg::START_CODE || b == afd_pkg::ESCAPE_CODE ||
                     $urandom_range(19) == 0)) begin
      put_raw(afd_pkg::ESCAPE_CODE);
      put_raw(b ^ afd_pkg::ESCAPE_XOR);
    end else begin
      put_raw(b);
    end
  endtask

  // This sends a frame whose data comes from body_q. Without a checksum the frame is
  // left open, and with spoil set the checksum is made wrong on purpose.
  task automatic put_frame(input int len_field, input logic [7:0] api, input bit with_cks,
                           input bit spoil);
    logic [7:0] sum;
    logic [7:0] cks;
    sum = api;
    put_raw(afd_pkg::START_CODE);
    put_coded(len_field[15:8]);
    put_coded(len_field[7:0]);
    put_coded(api);
    foreach (body_q[i]) begin
      put_coded(body_q[i]);
      sum = sum + body_q[i];
    end
    if (with_cks) begin
      cks = afd_pkg::SUM_GOOD - sum;
      if (spoil) begin
        cks = cks ^ 8'($urandom_range(255, 1));
      end
      put_coded(cks);
    end
  endtask

  task automatic fill_body(input int n);
    body_q.delete();
    repeat (n) body_q.push_back(pick_byte());
  endtask

  // This adds one random unit of line traffic. Most units are well-formed short frames with
  // random content. The rest are bad checksums, noise between frames, frames cut short by
  // a start byte, an escape followed by a start, and length fields that do not match the data.
  task automatic put_traffic();
    int r;
    int n;
    r = $urandom_range(99);
    n = $urandom_range(8);
    fill_body(n);
    if (r < 60) begin
      put_frame(n + 1, pick_byte(), 1'b1, 1'b0);
    end else if (r < 70) begin
      put_frame(n + 1, pick_byte(), 1'b1, 1'b1);
    end else if (r < 78) begin
      repeat ($urandom_range(4, 1)) put_raw(pick_byte());
    end else if (r < 86) begin
      put_frame(n + 1 + $urandom_range(4, 1), pick_byte(), 1'b0, 1'b0);
      put_raw(afd_pkg::START_CODE);
    end else if (r < 92) begin
      put_frame(n + 2, pick_byte(), 1'b0, 1'b0);
      put_raw(afd_pkg::ESCAPE_CODE);
      put_raw(afd_pkg::START_CODE);
    end else begin
      put_frame($urandom_range(65535), pick_byte(), 1'b1, 1'($urandom_range(1)));
    end
  endtask

  // This waits until every request has been taken and every expected result has arrived.
  // It then waits out SETTLE_CYCLES for a last byte that gives no result. The check is
  // made on the falling edge so that all updates of the rising edge are settled.
  task automatic wait_quiet();
    do @(negedge clk); while (rx_bytes_q.size() != 0 || in_valid || events_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // This writes the escape mode register through its handshake. The write is made only
  // while the block is quiet, so the predictor may take the new mode at the same edge.
  task automatic write_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_escape_enable <= v;
    do @(posedge clk); while (!cfg_ready);
    esc_mode = v;
    cfg_valid <= 1'b0;
  endtask

  // The driver presents the queued bytes. The byte that the block takes at an edge is
  // given to the predictor at that same edge. A stalled request keeps its byte. A new byte
  // or an idle gap is chosen only once the current request has been taken.
  always @(posedge clk) begin : rx_driver
    deframed_t got;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (deframe_byte(in_rx_byte, got)) begin
          events_due.push_back(got);
        end
      end
      if (!in_valid || !in_stall) begin
        if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The monitor compares each result that the block delivers with the oldest expected result,
  // field by field. It also applies random back-pressure at the rate of the current phase.
  always @(posedge clk) begin : event_monitor
    deframed_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (events_due.size() == 0) begin
          $error("result with no pending request: event_res %0d", out_event_res);
          mismatches++;
        end else begin
          want = events_due.pop_front();
          compare_field("event_res", want.event_res, out_event_res);
          compare_field("data_byte", want.data_byte, out_data_byte);
          compare_field("data_index", want.data_index, out_data_index);
          compare_field("api_id", want.api_id, out_api_id);
          compare_field("data_length", want.data_length, out_data_length);
          compare_field("checksum_byte", want.checksum_byte, out_checksum_byte);
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int built_at;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed part runs in escaped mode, the mode after reset, with no idling.
    // Stray bytes, among them an escape code, are dropped while hunting.
    put_raw(8'hFF);
    put_raw(afd_pkg::ESCAPE_CODE);
    // This is a good frame at the extreme API id. Its data holds a start code and an escape
    // code, which need escaping, and 0xFF.
    body_q = '{afd_pkg::START_CODE, afd_pkg::ESCAPE_CODE, 8'hFF};
    put_frame(4, 8'hFF, 1'b1, 1'b0);
    // An escape followed by an escape gives data 0x5D. Then an escape followed by a start
    // gives an unexpected start.
    put_raw(afd_pkg::START_CODE);
    put_raw(8'h00);
    put_raw(8'h05);
    put_raw(8'hA1);
    put_raw(afd_pkg::ESCAPE_CODE);
    put_raw(afd_pkg::ESCAPE_CODE);
    put_raw(afd_pkg::ESCAPE_CODE);
    put_raw(afd_pkg::START_CODE);
    // This frame has no data, API id zero and a wrong checksum.
    body_q.delete();
    put_frame(1, 8'h00, 1'b1, 1'b1);
    // This frame is left open with an escape pending, so the mode change below falls
    // inside a frame.
    put_raw(afd_pkg::START_CODE);
    put_raw(afd_pkg::ESCAPE_CODE);

    // Each random phase sets the mode and an idling profile. The phases together cover
    // both modes with every profile. Every odd phase begins with a long frame: a good frame
    // that fills the buffer, a zero length, or a length beyond the buffer.
    for (int ph = 0; ph < 8; ph++) begin
      wait_quiet();
      write_mode(1'(((ph >> 2) ^ ph) & 1));
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct = 32;
        end
      endcase
      built_at = bytes_built;
      if (ph % 2 == 1) begin
        case ((ph / 2) % 3)
          0: begin
            fill_body(FRAME_MAX_DATA);
            put_frame(FRAME_MAX_DATA + 1, pick_byte(), 1'b1, 1'b0);
          end
          1: begin
            fill_body(FRAME_MAX_DATA + 1);
            put_frame(0, pick_byte(), 1'b0, 1'b0);
          end
          default: begin
            fill_body(FRAME_MAX_DATA + 1);
            put_frame($urandom_range(65535, FRAME_MAX_DATA + 2), pick_byte(), 1'b0, 1'b0);
          end
        endcase
      end
      while (bytes_built - built_at < ((ph % 2 == 1) ? 200 : 70)) begin
        put_traffic();
      end
      // A frame header is left open before the next mode change. This is done only when
      // the next phase starts with short frames, so that the next long frame is not lost.
      if (ph % 2 == 1 && $urandom_range(1) == 1) begin
        put_raw(afd_pkg::START_CODE);
        put_coded(pick_byte());
        if (esc_mode && $urandom_range(1) == 1) begin
          put_raw(afd_pkg::ESCAPE_CODE);
        end
      end
    end

    wait_quiet();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/afd_pkg.sv
sv/afd_front.sv
sv/afd_queue.sv
sv/afd_back.sv
sv/api_frame_deframer_unit.sv
tb/tb_top.sv
